// ===== rtl/chol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factor and triangular solve: shared definitions
// Result codes, input modes and the command and status records that pass
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package chol_pkg;

  // Widest addresses of the stores, set by the largest supported order (8).
  localparam int ADDR_W = 6;
  localparam int VEC_W  = 3;
  // Loop counters and the order in use hold values up to eight.
  localparam int CNT_W  = 4;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BWD  = 2'd2;

  localparam logic [1:0] KIND_FACTOR   = 2'd0;
  localparam logic [1:0] KIND_SOLUTION = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NOT_PD    = 2'd1;
  localparam logic [1:0] ERR_NO_FACTOR = 2'd2;

  typedef enum logic [1:0] {
    WSRC_INPUT = 2'd0,
    WSRC_DIV   = 2'd1,
    WSRC_SQRT  = 2'd2
  } wsrc_e;

  typedef enum logic [1:0] {
    VSEL_ZERO = 2'd0,
    VSEL_FAC  = 2'd1,
    VSEL_VEC  = 2'd2
  } vsel_e;

  typedef struct packed {
    logic [ADDR_W-1:0] mat_raddr;
    logic [ADDR_W-1:0] mat_waddr;
    logic              mat_we;
    logic [ADDR_W-1:0] fac_raddr;
    logic [ADDR_W-1:0] fac_waddr;
    logic              fac_we;
    wsrc_e             fac_wsrc;
    logic [VEC_W-1:0]  vec_raddr;
    logic [VEC_W-1:0]  vec_waddr;
    logic              vec_we;
    wsrc_e             vec_wsrc;
    logic              acc_load;
    logic              acc_from_vec;
    logic              acc_sub;
    logic              lat_a;
    logic              mul;
    logic              mul_from_vec;
    logic              div_start;
    logic              sqrt_start;
    logic              emit;
    logic [1:0]        kind;
    logic [2:0]        row;
    logic [2:0]        col;
    logic [1:0]        err;
    logic              last;
    vsel_e             vsel;
  } cmd_t;

  typedef struct packed {
    logic acc_nonpos;
    logic busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cholesky_factor_and_triangular_solve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factor and triangular solve
// Fixed-point Q16.16 Cholesky factorization with forward and backward solve.
// ----------------------------------------------------------------------------
// Usage. The input channel carries matrix entries (mode 0) and vector
// elements (modes 1 and 2). Each transfer is stored as it is taken. The entry
// flagged last starts the factorization of the lower triangle; the factor is
// then streamed row by row, or a single error result appears if a pivot sum
// is not positive. A vector element flagged last starts a forward solve with
// L or a backward solve with L transposed, and the solution streams out in
// index order. Without a valid factor a solve gives one error result.
// Work. Every off-diagonal factor entry takes one multiply-accumulate pass per
// term plus a bit-serial divide; every pivot takes a square root. A solve of
// order d takes d divides plus one multiply-accumulate pass per term. The
// divider and the square root unit set the run time; one item is handled at
// a time and the input stalls until the last result has been placed in the
// output register.
// Reset clears the order register to eight and drops the factor; the stores
// hold no defined contents until written. When the receiver stalls, the
// result stays in the output register and the sequencer waits.
// The configuration channel writes the order; it is taken only while idle.
// ----------------------------------------------------------------------------
module cholesky_factor_and_triangular_solve #(
  parameter int MAX_DIM = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         error_code_o,
  output logic               out_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i
);
  import chol_pkg::*;

  // The sequencer owns all loop indexes; the datapath only executes commands.
  cmd_t cmd;
  sts_t sts;

  chol_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .last_i     (last_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  chol_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .error_code_o(error_code_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== rtl/chol_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/chol_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky datapath
// Stores, multiply-accumulate, bit-serial divider, square root unit and the
// output register, all driven by the sequencer's command record.
// ----------------------------------------------------------------------------
module chol_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chol_pkg::cmd_t      cmd_i,
  output chol_pkg::sts_t      sts_o,
  input  logic signed [31:0]  value_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [1:0]          kind_o,
  output logic [2:0]          out_row_o,
  output logic [2:0]          out_col_o,
  output logic signed [31:0]  out_value_o,
  output logic [1:0]          error_code_o,
  output logic                out_last_o
);
  import chol_pkg::*;

  localparam int MDEPTH = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(MDEPTH);
  localparam int VW     = $clog2(MAX_DIM);

  logic [31:0] mat_rdata, fac_rdata, vec_rdata;
  logic [31:0] fac_wdata, vec_wdata;
  logic [31:0] div_res, sqrt_res;

  logic signed [63:0] acc_q, prod_q;
  logic signed [31:0] opa_q;
  logic signed [64:0] diff;
  logic signed [31:0] mul_b, pivot;

  // Shared iteration counter for the divider and the square root unit.
  logic [6:0]  cnt_q;
  logic        sqrt_q;
  logic [63:0] dq_q;
  logic [31:0] drem_q, ddiv_q;
  logic        dneg_q;
  logic [31:0] rs;
  logic        ge;
  logic [63:0] sx_q, sr_q, sbit_q, strial;

  logic        out_valid_q;

  chol_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mat_we),
    .waddr_i(cmd_i.mat_waddr[AW-1:0]),
    .wdata_i(value_i),
    .raddr_i(cmd_i.mat_raddr[AW-1:0]),
    .rdata_o(mat_rdata)
  );

  chol_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_fac (
    .clk_i  (clk_i),
    .we_i   (cmd_i.fac_we),
    .waddr_i(cmd_i.fac_waddr[AW-1:0]),
    .wdata_i(fac_wdata),
    .raddr_i(cmd_i.fac_raddr[AW-1:0]),
    .rdata_o(fac_rdata)
  );

  chol_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_vec (
    .clk_i  (clk_i),
    .we_i   (cmd_i.vec_we),
    .waddr_i(cmd_i.vec_waddr[VW-1:0]),
    .wdata_i(vec_wdata),
    .raddr_i(cmd_i.vec_raddr[VW-1:0]),
    .rdata_o(vec_rdata)
  );

  assign fac_wdata = (cmd_i.fac_wsrc == WSRC_SQRT) ? sqrt_res : div_res;
  assign vec_wdata = (cmd_i.vec_wsrc == WSRC_INPUT) ? value_i : div_res;

  // Multiply-accumulate. In a solve both operands arrive together from the
  // factor and vector stores; in the factorization the first one is latched.
  assign mul_b = cmd_i.mul_from_vec ? vec_rdata : fac_rdata;
  assign diff  = {acc_q[63], acc_q} - {prod_q[63], prod_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      opa_q <= fac_rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= (cmd_i.mul_from_vec ? $signed(fac_rdata) : opa_q) * mul_b;
    end
    if (cmd_i.acc_load) begin
      acc_q <= cmd_i.acc_from_vec ? {{16{vec_rdata[31]}}, vec_rdata, 16'd0}
                                  : {{16{mat_rdata[31]}}, mat_rdata, 16'd0};
    end else if (cmd_i.acc_sub) begin
      if (diff[64] != diff[63]) begin
        acc_q <= diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc_q <= diff[63:0];
      end
    end
  end

  // Divider: restoring, one quotient bit per cycle. The pivot is clamped to at least one LSB.
  assign pivot  = ($signed(fac_rdata) < 32'sd1) ? 32'sd1 : fac_rdata;
  assign rs     = {drem_q[30:0], dq_q[63]};
  assign ge     = (rs >= ddiv_q);
  assign strial = sr_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      cnt_q  <= 7'd64;
      sqrt_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      cnt_q  <= 7'd32;
      sqrt_q <= 1'b1;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dneg_q <= acc_q[63];
      dq_q   <= acc_q[63] ? 64'(-acc_q) : acc_q;
      drem_q <= '0;
      ddiv_q <= pivot;
    end else if (cnt_q != '0 && !sqrt_q) begin
      drem_q <= ge ? rs - ddiv_q : rs;
      dq_q   <= {dq_q[62:0], ge};
    end
    if (cmd_i.sqrt_start) begin
      sx_q   <= acc_q;
      sr_q   <= '0;
      sbit_q <= 64'd1 << 62;
    end else if (cnt_q != '0 && sqrt_q) begin
      if (sx_q >= strial) begin
        sx_q <= sx_q - strial;
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  always_comb begin
    if (!dneg_q) begin
      div_res = (dq_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq_q[31:0];
    end else begin
      div_res = (dq_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-dq_q[31:0]);
    end
    sqrt_res = (sr_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sr_q[31:0];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o       <= cmd_i.kind;
      out_row_o    <= cmd_i.row;
      out_col_o    <= cmd_i.col;
      error_code_o <= cmd_i.err;
      out_last_o   <= cmd_i.last;
      case (cmd_i.vsel)
        VSEL_FAC: out_value_o <= fac_rdata;
        VSEL_VEC: out_value_o <= vec_rdata;
        default:  out_value_o <= '0;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.acc_nonpos  = acc_q[63] || (acc_q == '0);
  assign sts_o.busy        = (cnt_q != '0);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/chol_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky sequencer
// Walks the factorization, the two solves and the result streams, and holds
// the order register and the factor-valid flag.
// ----------------------------------------------------------------------------
module chol_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  input  logic [2:0]     row_i,
  input  logic [2:0]     col_i,
  input  logic           last_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_data_i,
  output chol_pkg::cmd_t cmd_o,
  input  chol_pkg::sts_t sts_i
);
  import chol_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE   = 25'd1 << 0,
    ST_F_ACC0 = 25'd1 << 1,
    ST_F_ACC1 = 25'd1 << 2,
    ST_F_RA   = 25'd1 << 3,
    ST_F_RB   = 25'd1 << 4,
    ST_F_MUL  = 25'd1 << 5,
    ST_F_SUB  = 25'd1 << 6,
    ST_F_PIV  = 25'd1 << 7,
    ST_F_DIV  = 25'd1 << 8,
    ST_F_DW   = 25'd1 << 9,
    ST_F_SQW  = 25'd1 << 10,
    ST_F_FAIL = 25'd1 << 11,
    ST_F_ERD  = 25'd1 << 12,
    ST_F_EOUT = 25'd1 << 13,
    ST_V_ACC0 = 25'd1 << 14,
    ST_V_ACC1 = 25'd1 << 15,
    ST_V_RD   = 25'd1 << 16,
    ST_V_MUL  = 25'd1 << 17,
    ST_V_SUB  = 25'd1 << 18,
    ST_V_PIV  = 25'd1 << 19,
    ST_V_DIV  = 25'd1 << 20,
    ST_V_DW   = 25'd1 << 21,
    ST_V_ERD  = 25'd1 << 22,
    ST_V_EOUT = 25'd1 << 23,
    ST_V_ERR  = 25'd1 << 24
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [3:0] dim_q;
  logic       fvalid_q, fvalid_d;
  logic       bwd_q, bwd_d;
  logic [CNT_W-1:0] d, dm1, idx;
  logic       idle, accept;
  logic [2:0] rr, cc;

  function automatic logic [ADDR_W-1:0] maddr(input logic [CNT_W-1:0] r,
                                              input logic [CNT_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  assign idle        = (state_q == ST_IDLE);
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign accept      = in_valid_i && idle;

  always_comb begin
    if (dim_q < 4'd2) begin
      d = CNT_W'(2);
    end else if (dim_q > CNT_W'(MAX_DIM)) begin
      d = CNT_W'(MAX_DIM);
    end else begin
      d = dim_q;
    end
  end
  assign dm1 = d - CNT_W'(1);
  assign idx = bwd_q ? dm1 - i_q : i_q;

  // Matrix entries above the diagonal go to the mirror place.
  assign rr = (col_i > row_i) ? col_i : row_i;
  assign cc = (col_i > row_i) ? row_i : col_i;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    fvalid_d = fvalid_q;
    bwd_d    = bwd_q;
    cmd_o    = '0;
    cmd_o.fac_wsrc  = WSRC_DIV;
    cmd_o.vec_wsrc  = WSRC_DIV;
    cmd_o.vsel      = VSEL_ZERO;
    cmd_o.mat_raddr = maddr(i_q, j_q);
    cmd_o.mat_waddr = maddr({1'b0, rr}, {1'b0, cc});
    cmd_o.vec_waddr = VEC_W'(idx);
    cmd_o.vec_raddr = VEC_W'(idx);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.mat_we = ({1'b0, rr} < CNT_W'(MAX_DIM));
            if (last_i) begin
              i_d     = '0;
              j_d     = '0;
              state_d = ST_F_ACC0;
            end
          end else if (mode_i == MODE_FWD || mode_i == MODE_BWD) begin
            cmd_o.vec_we    = ({1'b0, row_i} < CNT_W'(MAX_DIM));
            cmd_o.vec_waddr = VEC_W'(row_i);
            cmd_o.vec_wsrc  = WSRC_INPUT;
            if (last_i) begin
              i_d     = '0;
              bwd_d   = (mode_i == MODE_BWD);
              state_d = fvalid_q ? ST_V_ACC0 : ST_V_ERR;
            end
          end
        end
      end
      ST_F_ACC0: state_d = ST_F_ACC1;
      ST_F_ACC1: begin
        cmd_o.acc_load = 1'b1;
        k_d     = '0;
        state_d = (j_q != '0) ? ST_F_RA : ST_F_PIV;
      end
      ST_F_RA: begin
        cmd_o.fac_raddr = maddr(i_q, k_q);
        state_d = ST_F_RB;
      end
      ST_F_RB: begin
        cmd_o.fac_raddr = maddr(j_q, k_q);
        cmd_o.lat_a     = 1'b1;
        state_d = ST_F_MUL;
      end
      ST_F_MUL: begin
        cmd_o.fac_raddr = maddr(j_q, k_q);
        cmd_o.mul       = 1'b1;
        state_d = ST_F_SUB;
      end
      ST_F_SUB: begin
        cmd_o.acc_sub = 1'b1;
        k_d     = k_q + CNT_W'(1);
        state_d = (k_q + CNT_W'(1) < j_q) ? ST_F_RA : ST_F_PIV;
      end
      ST_F_PIV: begin
        cmd_o.fac_raddr = maddr(j_q, j_q);
        if (j_q < i_q) begin
          state_d = ST_F_DIV;
        end else if (sts_i.acc_nonpos) begin
          fvalid_d = 1'b0;
          state_d  = ST_F_FAIL;
        end else begin
          cmd_o.sqrt_start = 1'b1;
          state_d = ST_F_SQW;
        end
      end
      ST_F_DIV: begin
        cmd_o.fac_raddr = maddr(j_q, j_q);
        cmd_o.div_start = 1'b1;
        state_d = ST_F_DW;
      end
      ST_F_DW: begin
        if (!sts_i.busy) begin
          cmd_o.fac_we    = 1'b1;
          cmd_o.fac_waddr = maddr(i_q, j_q);
          j_d     = j_q + CNT_W'(1);
          state_d = ST_F_ACC0;
        end
      end
      ST_F_SQW: begin
        if (!sts_i.busy) begin
          cmd_o.fac_we    = 1'b1;
          cmd_o.fac_waddr = maddr(i_q, i_q);
          cmd_o.fac_wsrc  = WSRC_SQRT;
          j_d = '0;
          if (i_q == dm1) begin
            fvalid_d = 1'b1;
            i_d      = '0;
            state_d  = ST_F_ERD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_F_ACC0;
          end
        end
      end
      ST_F_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_ERROR;
          cmd_o.row  = i_q[2:0];
          cmd_o.err  = ERR_NOT_PD;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_F_ERD: begin
        cmd_o.fac_raddr = maddr(i_q, j_q);
        state_d = ST_F_EOUT;
      end
      ST_F_EOUT: begin
        cmd_o.fac_raddr = maddr(i_q, j_q);
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_FACTOR;
          cmd_o.row  = i_q[2:0];
          cmd_o.col  = j_q[2:0];
          cmd_o.err  = ERR_NONE;
          cmd_o.vsel = VSEL_FAC;
          cmd_o.last = (i_q == dm1) && (j_q == i_q);
          if (j_q == i_q) begin
            j_d     = '0;
            i_d     = i_q + CNT_W'(1);
            state_d = (i_q == dm1) ? ST_IDLE : ST_F_ERD;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = ST_F_ERD;
          end
        end
      end
      ST_V_ACC0: state_d = ST_V_ACC1;
      ST_V_ACC1: begin
        cmd_o.acc_load     = 1'b1;
        cmd_o.acc_from_vec = 1'b1;
        if (bwd_q) begin
          j_d     = idx + CNT_W'(1);
          state_d = (idx < dm1) ? ST_V_RD : ST_V_PIV;
        end else begin
          j_d     = '0;
          state_d = (idx != '0) ? ST_V_RD : ST_V_PIV;
        end
      end
      ST_V_RD, ST_V_MUL: begin
        cmd_o.fac_raddr = bwd_q ? maddr(j_q, idx) : maddr(idx, j_q);
        cmd_o.vec_raddr = VEC_W'(j_q);
        if (state_q == ST_V_RD) begin
          cmd_o.lat_a = 1'b0;
          state_d = ST_V_MUL;
        end else begin
          cmd_o.mul          = 1'b1;
          cmd_o.mul_from_vec = 1'b1;
          state_d = ST_V_SUB;
        end
      end
      ST_V_SUB: begin
        cmd_o.acc_sub = 1'b1;
        j_d = j_q + CNT_W'(1);
        if (bwd_q) begin
          state_d = (j_q < dm1) ? ST_V_RD : ST_V_PIV;
        end else begin
          state_d = (j_q + CNT_W'(1) < idx) ? ST_V_RD : ST_V_PIV;
        end
      end
      ST_V_PIV: begin
        cmd_o.fac_raddr = maddr(idx, idx);
        state_d = ST_V_DIV;
      end
      ST_V_DIV: begin
        cmd_o.fac_raddr = maddr(idx, idx);
        cmd_o.div_start = 1'b1;
        state_d = ST_V_DW;
      end
      ST_V_DW: begin
        if (!sts_i.busy) begin
          cmd_o.vec_we = 1'b1;
          if (i_q == dm1) begin
            i_d     = '0;
            bwd_d   = 1'b0;
            state_d = ST_V_ERD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_V_ACC0;
          end
        end
      end
      ST_V_ERD: state_d = ST_V_EOUT;
      ST_V_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_SOLUTION;
          cmd_o.row  = i_q[2:0];
          cmd_o.err  = ERR_NONE;
          cmd_o.vsel = VSEL_VEC;
          cmd_o.last = (i_q == dm1);
          i_d        = i_q + CNT_W'(1);
          state_d    = (i_q == dm1) ? ST_IDLE : ST_V_ERD;
        end
      end
      ST_V_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_ERROR;
          cmd_o.err  = ERR_NO_FACTOR;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A new order makes the stored factor meaningless.
    if (cfg_valid_i && idle) begin
      fvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      fvalid_q <= 1'b0;
      bwd_q    <= 1'b0;
      dim_q    <= 4'd8;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      fvalid_q <= fvalid_d;
      bwd_q    <= bwd_d;
      if (cfg_valid_i && idle) begin
        dim_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== rtl/chol_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky port checker
// Watches the top-level ports for handshake and result-format violations.
// ----------------------------------------------------------------------------
module chol_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic [2:0]         out_row_o,
  input logic [2:0]         out_col_o,
  input logic signed [31:0] out_value_o,
  input logic [1:0]         error_code_o,
  input logic               out_last_o
);
  import chol_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o))
    else $error("stalled result dropped or changed");

  a_err_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |->
      out_last_o && error_code_o != ERR_NONE && out_value_o == 0 && out_col_o == 0)
    else $error("malformed error result");

  a_fac_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FACTOR |-> out_col_o <= out_row_o && error_code_o == ERR_NONE)
    else $error("factor entry above the diagonal");

  a_busy_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> in_stall_o)
    else $error("input taken while a run is still streaming");

endmodule

bind cholesky_factor_and_triangular_solve chol_checker u_chol_checker (.*);

// ===== dv/tb_cholesky_factor_and_triangular_solve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Cholesky factor and triangular solve block
// Loads symmetric matrices and solve vectors through the input channel and
// changes the order through the configuration channel. A fixed-point model
// of the factorization and both solves predicts every result, and each
// result is compared field by field as it is transferred out.
// ----------------------------------------------------------------------------
module tb_cholesky_factor_and_triangular_solve;
  import chol_pkg::*;

  // The fourth input mode has no name in the package; the block ignores it.
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic [1:0]  err;
    logic        last;
  } chol_result_t;

  // Holds a shadow copy of the block's stores and the queue of factor
  // entries, solution elements and errors that the block still owes us.
  class chol_scoreboard;
    logic signed [31:0] mat[64];
    logic signed [31:0] fac[64];
    logic signed [31:0] vec[8];
    bit                 fac_ok;
    logic [3:0]         order_reg;
    chol_result_t       owed[$];
    int                 failures;

    function new();
      foreach (mat[i]) begin
        mat[i] = '0;
        fac[i] = '0;
      end
      foreach (vec[i]) vec[i] = '0;
      fac_ok    = 0;
      order_reg = 4'd8;
      failures  = 0;
    endfunction

    function longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      return s[63:0];
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function logic signed [31:0] quotient(longint sum, logic signed [31:0] pivot);
      longint p;
      p = longint'(pivot);
      if (p < 1) p = 1;
      return clip32(sum / p);
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function int order_in_use();
      if (order_reg < 2) return 2;
      if (order_reg > 8) return 8;
      return order_reg;
    endfunction

    function void owe(logic [1:0] kind, int r, int c, logic [31:0] v, logic [1:0] err,
                      bit last);
      chol_result_t e;
      e.kind  = kind;
      e.row   = r[2:0];
      e.col   = c[2:0];
      e.value = v;
      e.err   = err;
      e.last  = last;
      owed.push_back(e);
    endfunction

    // Returns the row whose pivot sum is not positive, or -1.
    function int factor_matrix(int d);
      longint sum;
      longint unsigned rt;
      for (int i = 0; i < d; i++) begin
        for (int j = 0; j < i; j++) begin
          sum = longint'(mat[i*8+j]) * 65536;
          for (int k = 0; k < j; k++)
            sum = sat_sum(sum, -(longint'(fac[i*8+k]) * longint'(fac[j*8+k])));
          fac[i*8+j] = quotient(sum, fac[j*8+j]);
        end
        sum = longint'(mat[i*8+i]) * 65536;
        for (int k = 0; k < i; k++)
          sum = sat_sum(sum, -(longint'(fac[i*8+k]) * longint'(fac[i*8+k])));
        if (sum <= 0) return i;
        rt = root64(sum);
        fac[i*8+i] = (rt > 64'd2147483647) ? 32'h7fff_ffff : rt[31:0];
      end
      return -1;
    endfunction

    function void solve_vector(int d, bit backward);
      longint sum;
      int i;
      for (int n = 0; n < d; n++) begin
        i = backward ? d - 1 - n : n;
        sum = longint'(vec[i]) * 65536;
        if (backward) begin
          for (int j = i + 1; j < d; j++)
            sum = sat_sum(sum, -(longint'(fac[j*8+i]) * longint'(vec[j])));
        end else begin
          for (int j = 0; j < i; j++)
            sum = sat_sum(sum, -(longint'(fac[i*8+j]) * longint'(vec[j])));
        end
        vec[i] = quotient(sum, fac[i*8+i]);
      end
    endfunction

    function void note_order(logic [3:0] v);
      order_reg = v;
      fac_ok    = 0;
    endfunction

    function void note_item(logic [1:0] mode, logic [2:0] row, logic [2:0] col,
                            logic [31:0] value, bit last);
      int d, r, c, bad;
      d = order_in_use();
      r = row;
      c = col;
      if (mode == MODE_IGNORED) return;
      if (mode == MODE_LOAD) begin
        // An entry above the diagonal lands at its mirror place.
        if (c > r) begin
          r = col;
          c = row;
        end
        mat[r*8+c] = value;
        if (!last) return;
        bad = factor_matrix(d);
        if (bad >= 0) begin
          fac_ok = 0;
          owe(KIND_ERROR, bad, 0, '0, ERR_NOT_PD, 1);
          return;
        end
        fac_ok = 1;
        for (int i = 0; i < d; i++)
          for (int j = 0; j <= i; j++)
            owe(KIND_FACTOR, i, j, fac[i*8+j], ERR_NONE, (i == d - 1) && (j == i));
        return;
      end
      vec[r] = value;
      if (!last) return;
      if (!fac_ok) begin
        owe(KIND_ERROR, 0, 0, '0, ERR_NO_FACTOR, 1);
        return;
      end
      solve_vector(d, mode == MODE_BWD);
      for (int i = 0; i < d; i++) owe(KIND_SOLUTION, i, 0, vec[i], ERR_NONE, i == d - 1);
    endfunction

    function void check_result(chol_result_t got);
      chol_result_t e;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result kind=%0d row=%0d col=%0d value=%h err=%0d last=%0b",
                   got.kind, got.row, got.col, got.value, got.err, got.last);
        return;
      end
      e = owed.pop_front();
      if (got.kind !== e.kind || got.row !== e.row || got.col !== e.col ||
          got.value !== e.value || got.err !== e.err || got.last !== e.last) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: expected kind=%0d row=%0d col=%0d value=%h err=%0d ",
                    "last=%0b, got kind=%0d row=%0d col=%0d value=%h err=%0d last=%0b"},
                   e.kind, e.row, e.col, e.value, e.err, e.last,
                   got.kind, got.row, got.col, got.value, got.err, got.last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic [2:0]         row_i = '0;
  logic [2:0]         col_i = '0;
  logic signed [31:0] value_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [2:0]         out_row_o;
  logic [2:0]         out_col_o;
  logic signed [31:0] out_value_o;
  logic [1:0]         error_code_o;
  logic               out_last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [3:0]         cfg_data_i = '0;

  chol_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int cur_order  = 8;

  cholesky_factor_and_triangular_solve #(.MAX_DIM(8)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .row_i(row_i), .col_i(col_i), .value_i(value_i), .last_i(last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .kind_o(kind_o), .out_row_o(out_row_o), .out_col_o(out_col_o),
    .out_value_o(out_value_o), .error_code_o(error_code_o), .out_last_o(out_last_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side. Outputs are sampled at the edge, before the block's own
  // registers update, and the stall for the next cycle is chosen here. The
  // stall pattern changes its character whenever stall_phase wraps: no
  // stalls at all, occasional stalls, or mostly stalled.
  int stall_phase = 0;
  int stall_style = 0;
  always @(posedge clk_i) begin
    chol_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind  = kind_o;
      got.row   = out_row_o;
      got.col   = out_col_o;
      got.value = out_value_o;
      got.err   = error_code_o;
      got.last  = out_last_o;
      sb.check_result(got);
    end
    if (stall_phase == 0) stall_style = $urandom_range(0, 2);
    stall_phase = (stall_phase + 1) % 64;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // One input transfer. The sender works in bursts, and valid
  // drops between bursts so that valid gets one assignment per edge.
  task automatic send_item(logic [1:0] mode, logic [2:0] row, logic [2:0] col,
                           logic [31:0] value, bit last);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(mode, row, col, value, last);
    burst_left--;
    items_sent++;
  endtask

  // Waits until every owed result has been transferred, then lets the block
  // finish any store-only transfer still in flight.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_order(logic [3:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.note_order(v);
    cur_order = sb.order_in_use();
  endtask

  // Loads the whole lower triangle of order d in shuffled order, with the
  // last flag on the final transfer. Tame content is diagonally dominant so
  // that the factor exists; wild content is fully random.
  task automatic load_matrix(int d, bit wild);
    int rs[$], cs[$];
    int k, t;
    logic [31:0] v;
    for (int r = 0; r < d; r++)
      for (int c = 0; c <= r; c++) begin
        rs.push_back(r);
        cs.push_back(c);
      end
    for (int i = rs.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = rs[i]; rs[i] = rs[k]; rs[k] = t;
      t = cs[i]; cs[i] = cs[k]; cs[k] = t;
    end
    for (int i = 0; i < rs.size(); i++) begin
      if (wild) v = $urandom();
      else if (rs[i] == cs[i]) v = (d << 16) + $urandom_range(0, 32'h0008_0000);
      else v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      // Now and then the entry is sent at its place above the diagonal.
      if (rs[i] != cs[i] && $urandom_range(0, 3) == 0)
        send_item(MODE_LOAD, 3'(cs[i]), 3'(rs[i]), v, i == rs.size() - 1);
      else
        send_item(MODE_LOAD, 3'(rs[i]), 3'(cs[i]), v, i == rs.size() - 1);
    end
  endtask

  // Sends all d vector elements in shuffled order, the last one flagged.
  task automatic load_vector(int d, logic [1:0] mode, bit wild);
    int idx[$];
    int k, t;
    logic [31:0] v;
    for (int i = 0; i < d; i++) idx.push_back(i);
    for (int i = d - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = idx[i]; idx[i] = idx[k]; idx[k] = t;
    end
    for (int i = 0; i < d; i++) begin
      v = wild ? $urandom() : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      send_item(mode, 3'(idx[i]), 3'($urandom_range(0, 7)), v, i == d - 1);
    end
  endtask

  initial begin
    int pick;
    int target;
    logic [3:0] ord;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A solve before any factor gives the no-factor error.
    send_item(MODE_FWD, 3'd0, 3'd7, 32'h7fff_ffff, 1'b1);
    // The first full load at order eight writes the lower triangle of the
    // matrix and factor stores, so no later run reads an unwritten entry.
    load_matrix(8, 1'b0);
    send_item(MODE_IGNORED, 3'd7, 3'd7, 32'hffff_ffff, 1'b1);
    load_vector(8, MODE_FWD, 1'b0);
    load_vector(8, MODE_BWD, 1'b1);
    // A single element flagged last re-solves the vector kept in place.
    send_item(MODE_BWD, 3'd3, 3'd5, 32'h8000_0000, 1'b1);
    send_item(MODE_FWD, 3'd5, 3'd0, 32'h7fff_ffff, 1'b1);
    // Order two: a zero pivot fails on the first row, a negative one later.
    write_order(4'd2);
    send_item(MODE_LOAD, 3'd0, 3'd0, 32'h0000_0000, 1'b1);
    send_item(MODE_LOAD, 3'd1, 3'd1, 32'h8000_0000, 1'b0);
    send_item(MODE_LOAD, 3'd0, 3'd1, 32'h7fff_ffff, 1'b0);
    send_item(MODE_LOAD, 3'd0, 3'd0, 32'h7fff_ffff, 1'b1);
    // A failed pivot leaves no factor to solve with.
    send_item(MODE_FWD, 3'd1, 3'd0, 32'h0001_0000, 1'b1);
    // Orders below two and above eight are clamped by the block.
    write_order(4'd0);
    load_matrix(cur_order, 1'b0);
    send_item(MODE_LOAD, 3'd6, 3'd2, 32'h1234_5678, 1'b0);
    load_vector(cur_order, MODE_BWD, 1'b0);
    write_order(4'd15);
    load_matrix(cur_order, 1'b0);
    load_vector(cur_order, MODE_FWD, 1'b1);

    // Random part: mostly complete matrices and vectors with random content,
    // mixed with order changes and stray or ignored transfers. It tops the
    // whole run up to at least 155 transfers.
    target = 155;
    while (items_sent < target) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        ord = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(2, 4));
        write_order(ord);
      end else if (pick <= 4) begin
        load_matrix(cur_order, $urandom_range(0, 4) == 0);
      end else if (pick <= 9) begin
        load_vector(cur_order, $urandom_range(0, 1) ? MODE_FWD : MODE_BWD,
                    $urandom_range(0, 3) == 0);
      end else if (pick == 10) begin
        send_item(MODE_IGNORED, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), $urandom(), 1'b0);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.failures == 0 && sb.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with the heaviest stalls.
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
